/* hdl/assert_macros.svh */
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on a rising clock, disabled during reset.
`define RTMP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check without a reset condition, for properties that also hold in reset.
`define RTMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/rtmp_pkg.sv */
// Package with the types and constants of the trimmed mean power block.
`timescale 1ns / 1ps
package rtmp_pkg;

  localparam int unsigned Samples = 20;
  localparam int unsigned SampleW = 8;
  localparam int unsigned CountW = 5;
  localparam int unsigned SumW = 13;
  localparam int unsigned MeanW = 8;
  localparam int unsigned PowerW = 7;

  localparam int unsigned Divisor = (Samples > 2) ? (Samples - 2) : 1;
  localparam int unsigned DivW = 5;
  localparam int unsigned RecipShift = 16;
  localparam int unsigned RecipW = 17;
  localparam int unsigned Recip = (1 << RecipShift) / Divisor;
  localparam int unsigned ProdW = SumW + RecipW;
  localparam int unsigned CheckW = SumW + DivW;

  localparam logic [CountW-1:0] LastCount = CountW'(Samples - 1);
  localparam logic [SampleW-1:0] FloorReset = 8'd40;
  localparam logic [SampleW-1:0] CeilingReset = 8'd188;
  localparam logic [SampleW-1:0] MinReset = 8'd255;

  localparam logic [SampleW-1:0] PowerBase = 8'd134;
  localparam logic [SampleW-1:0] PowerLow = 8'd40;
  localparam logic [SampleW-1:0] PowerHigh = 8'd120;

  localparam int unsigned AddrW = 3;
  localparam logic RegFloor = 1'b0;
  localparam logic RegCeiling = 1'b1;

  typedef struct packed {
    logic [SumW-1:0]    sum;
    logic [SampleW-1:0] min;
    logic [SampleW-1:0] max;
  } burst_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } hs_t;

endpackage

/* hdl/rtmp_front.sv */
// Front part: clamps samples and accumulates sum, minimum and maximum per burst.
`timescale 1ns / 1ps
module rtmp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rtmp_pkg::SampleW-1:0]  floor_i,
  input  logic [rtmp_pkg::SampleW-1:0]  ceiling_i,
  input  logic                          sample_valid_i,
  output logic                          sample_ready_o,
  input  logic [rtmp_pkg::SampleW-1:0]  sample_i,
  output rtmp_pkg::hs_t                 push_o,
  input  logic                          push_ready_i,
  output rtmp_pkg::burst_t              burst_o
);
  import rtmp_pkg::*;

  logic [CountW-1:0]  count_q, count_d;
  logic [SumW-1:0]    sum_q, sum_d;
  logic [SampleW-1:0] min_q, min_d;
  logic [SampleW-1:0] max_q, max_d;
  logic [SampleW-1:0] clamp_lo, clamp;
  logic               last, accept;

  assign last = (count_q == LastCount);
  assign sample_ready_o = !last || push_ready_i;
  assign accept = sample_valid_i && sample_ready_o;

  always_comb begin
    clamp_lo = (sample_i <= floor_i) ? floor_i : sample_i;
    clamp = (clamp_lo >= ceiling_i) ? ceiling_i : clamp_lo;
    sum_d = sum_q + SumW'(clamp);
    max_d = (clamp > max_q) ? clamp : max_q;
    min_d = (clamp < min_q) ? clamp : min_q;
    count_d = count_q + CountW'(1);
  end

  assign push_o.valid = accept && last;
  assign push_o.ready = push_ready_i;
  assign burst_o = '{sum: sum_d, min: min_d, max: max_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q <= '0;
      min_q <= MinReset;
      max_q <= '0;
    end else if (accept) begin
      if (last) begin
        count_q <= '0;
        sum_q <= '0;
        min_q <= MinReset;
        max_q <= '0;
      end else begin
        count_q <= count_d;
        sum_q <= sum_d;
        min_q <= min_d;
        max_q <= max_d;
      end
    end
  end

endmodule

/* hdl/rtmp_queue.sv */
// Two-entry queue of finished burst totals between the front and back parts.
`timescale 1ns / 1ps
module rtmp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_ready_o,
  input  rtmp_pkg::burst_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output rtmp_pkg::burst_t pop_data_o
);
  import rtmp_pkg::*;

  burst_t     entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q;
  logic       do_push, do_pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o = (fill_q != 2'd0);
  assign pop_data_o = entry_q[rd_ptr_q];
  assign do_push = push_i && push_ready_o;
  assign do_pop = pop_i && pop_valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/rtmp_back.sv */
// Back part: trims, divides by reciprocal and maps the mean to input power.
`timescale 1ns / 1ps
module rtmp_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         burst_valid_i,
  output logic                         burst_pop_o,
  input  rtmp_pkg::burst_t             burst_i,
  output logic                         result_valid_o,
  input  logic                         result_ready_i,
  output logic [rtmp_pkg::MeanW-1:0]   mean_o,
  output logic [rtmp_pkg::PowerW-1:0]  power_o
);
  import rtmp_pkg::*;

  logic               v1_q, v2_q, v3_q;
  logic               en1, en2, en3;
  logic [SumW-1:0]    trim_a, trim_b;
  logic [SumW-1:0]    t1_q, t2_q;
  logic [ProdW-1:0]   prod_q;
  logic [SumW-1:0]    quot0;
  logic [CheckW-1:0]  qd, rem;
  logic [SumW-1:0]    quot;
  logic [MeanW-1:0]   mean_d, mean_q;
  logic [SampleW-1:0] power_raw, power_cl;
  logic [PowerW-1:0]  power_q;

  assign en3 = !v3_q || result_ready_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign burst_pop_o = burst_valid_i && en1;

  always_comb begin
    trim_a = (burst_i.sum >= SumW'(burst_i.max)) ? burst_i.sum - SumW'(burst_i.max) : '0;
    trim_b = (trim_a >= SumW'(burst_i.min)) ? trim_a - SumW'(burst_i.min) : '0;
  end

  always_comb begin
    quot0 = SumW'(prod_q >> RecipShift);
    qd = CheckW'(quot0) * CheckW'(Divisor);
    rem = CheckW'(t2_q) - qd;
    quot = (rem >= CheckW'(Divisor)) ? quot0 + SumW'(1) : quot0;
    mean_d = quot[MeanW-1:0];
    power_raw = PowerBase - SampleW'(mean_d >> 1);
    if (power_raw < PowerLow) begin
      power_cl = PowerLow;
    end else if (power_raw > PowerHigh) begin
      power_cl = PowerHigh;
    end else begin
      power_cl = power_raw;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= burst_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      t1_q <= trim_b;
    end
    if (en2) begin
      t2_q <= t1_q;
      prod_q <= ProdW'(t1_q) * ProdW'(Recip);
    end
    if (en3) begin
      mean_q <= mean_d;
      power_q <= power_cl[PowerW-1:0];
    end
  end

  assign result_valid_o = v3_q;
  assign mean_o = mean_q;
  assign power_o = power_q;

endmodule

/* hdl/rssi_trimmed_mean_power.sv */
// Rate: one sample item per cycle, but the last sample of a burst waits while the
// queue is full; burst totals pass through a two-entry queue and a three-stage back pipe.
// The back pipe stages are trim, reciprocal multiply and correction.
// Reset is asynchronous and active low: it clears the burst state, the queue,
// the pipe valid bits, and sets floor to 40 and ceiling to 188.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rssi_trimmed_mean_power (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rtmp_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] rssi_sample
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata    // [7:0] mean_rssi, [14:8] input_power
);
  import rtmp_pkg::*;

  logic [SampleW-1:0] floor_q, ceiling_q;
  logic               cfg_wr;
  hs_t                push;
  logic               push_ready;
  burst_t             push_data, pop_data;
  logic               pop_valid, pop;
  logic [MeanW-1:0]   mean;
  logic [PowerW-1:0]  power;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FloorReset;
      ceiling_q <= CeilingReset;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        RegFloor:   floor_q <= pwdata[SampleW-1:0];
        RegCeiling: ceiling_q <= pwdata[SampleW-1:0];
        default:    floor_q <= floor_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegFloor:   prdata = {24'd0, floor_q};
      RegCeiling: prdata = {24'd0, ceiling_q};
      default:    prdata = '0;
    endcase
  end

  rtmp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .floor_i        (floor_q),
    .ceiling_i      (ceiling_q),
    .sample_valid_i (s_axis_tvalid),
    .sample_ready_o (s_axis_tready),
    .sample_i       (s_axis_tdata),
    .push_o         (push),
    .push_ready_i   (push_ready),
    .burst_o        (push_data)
  );

  rtmp_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push.valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_data_o   (pop_data)
  );

  rtmp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .burst_valid_i  (pop_valid),
    .burst_pop_o    (pop),
    .burst_i        (pop_data),
    .result_valid_o (m_axis_tvalid),
    .result_ready_i (m_axis_tready),
    .mean_o         (mean),
    .power_o        (power)
  );

  assign m_axis_tdata = {1'b0, power, mean};

  `RTMP_ASSERT(a_push_never_dropped, clk_i, rst_ni, push.valid |-> push.ready, "burst push while queue full")
  `RTMP_ASSERT(a_push_visible, clk_i, rst_ni, push.valid |=> pop_valid, "pushed burst not visible in queue")
  `RTMP_ASSERT(a_power_range, clk_i, rst_ni, m_axis_tvalid |-> (power >= PowerW'(PowerLow) && power <= PowerW'(PowerHigh)), "input power out of range")
  `RTMP_ASSERT_ALWAYS(a_pready_high, clk_i, pready && !(cfg_wr && !psel), "config write decode broken")

endmodule
